// ===== hdl/cobs_deframer_crc_check_core_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef COBS_DEFRAMER_CRC_CHECK_CORE_ASSERT_SVH
`define COBS_DEFRAMER_CRC_CHECK_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDCC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdcc: assertion failed");

// next-cycle implication, disabled during reset
`define CDCC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdcc: assertion failed");

`endif

// ===== hdl/cdcc_pkg.sv =====
// package: types, constants and crc step of the cobs deframer
`default_nettype none
package cdcc_pkg;

  localparam int BYTE_W          = 8;
  localparam int CRC_W           = 16;
  localparam int LEN_W           = 10;
  localparam int MAX_DECODED_DEF = 512;
  localparam int QUEUE_DEPTH     = 2;
  localparam int APB_AW          = 3;
  localparam int APB_DW          = 32;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
  localparam logic [CRC_W-1:0]  CRC_SEED_RST  = 16'hFFFF;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST   = 10'd10;
  localparam logic [BYTE_W-1:0] DELIM_BYTE    = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_LONG     = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic {
    REG_CRC_SEED = 1'b0,
    REG_MIN_LEN  = 1'b1
  } reg_idx_t;

  // one decoded event between front and back
  typedef struct packed {
    logic              is_delim;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  seed;
  } qent_t;

  // one result beat
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  crc;
  } res_t;

  // msb-first crc-16 over one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cdcc_rx_if.sv =====
// receive channel: one stuffed byte per beat
`default_nettype none
interface cdcc_rx_if
  import cdcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/cdcc_res_if.sv =====
// result channel: payload byte or end-of-frame status per beat
`default_nettype none
interface cdcc_res_if
  import cdcc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [1:0]        frame_status;
  logic [LEN_W-1:0]  frame_length;
  logic [CRC_W-1:0]  computed_crc;

  modport source (output valid, output out_kind, output out_byte, output frame_status,
                  output frame_length, output computed_crc, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input frame_status,
                  input frame_length, input computed_crc, output ready);
endinterface
`default_nettype wire

// ===== hdl/cobs_deframer_crc_check_core.sv =====
// top level: cobs deframer with crc-16 trailer check and apb registers
//
//   channel  dir  beat                                   handshake
//   rx       in   one stuffed byte, 0x00 ends the frame  valid/ready
//   res      out  payload byte or end-of-frame status    valid/ready
//   apb      in   crc_seed (0x0), min_frame_bytes (0x4)  psel/penable
//
// one byte per cycle sustained while res takes every beat; decode, the event queue
// and the one-byte crc step work on successive bytes; a byte is registered in a
// queue slot, then in the result register; payload bytes also wait in the holdback
// reset is synchronous; no clearing pass, the block takes bytes right after
// front and back stall apart through a two-entry queue; res stalls hold the back
`default_nettype none
module cobs_deframer_crc_check_core
  import cdcc_pkg::*;
#(
  parameter int MAX_DECODED = MAX_DECODED_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  cdcc_rx_if.sink                rx,
  cdcc_res_if.source             res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [CRC_W-1:0] crc_seed;
  logic [LEN_W-1:0] min_frame_bytes;
  reg_idx_t         reg_sel;
  logic             wr_en;
  logic             q_push, q_push_ready, q_pop_valid, q_pop_ready;
  qent_t            q_push_ent, q_pop_ent;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed        <= CRC_SEED_RST;
      min_frame_bytes <= MIN_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CRC_SEED: crc_seed        <= pwdata[CRC_W-1:0];
        REG_MIN_LEN:  min_frame_bytes <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_CRC_SEED: prdata = APB_DW'(crc_seed);
      REG_MIN_LEN:  prdata = APB_DW'(min_frame_bytes);
      default:      prdata = '0;
    endcase
  end

  cdcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .crc_seed (crc_seed),
    .q_push   (q_push),
    .q_ent    (q_push_ent),
    .q_ready  (q_push_ready)
  );

  cdcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ent   (q_push_ent),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_ent    (q_pop_ent),
    .pop_ready  (q_pop_ready)
  );

  cdcc_back #(
    .MAX_DECODED (MAX_DECODED)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ent_valid       (q_pop_valid),
    .ent             (q_pop_ent),
    .ent_ready       (q_pop_ready),
    .min_frame_bytes (min_frame_bytes),
    .res             (res)
  );

endmodule
`default_nettype wire

// ===== hdl/cdcc_front.sv =====
// front: cobs group tracking, turns stuffed bytes into decoded events
`default_nettype none
module cdcc_front
  import cdcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  cdcc_rx_if.sink               rx,
  input  wire logic [CRC_W-1:0] crc_seed,
  output logic                  q_push,
  output qent_t                 q_ent,
  input  wire logic             q_ready
);

  logic [BYTE_W-1:0] group_left, group_left_next;
  logic              zero_pending, zero_pending_next;
  logic              frame_open, frame_open_next;
  logic [CRC_W-1:0]  frame_seed, frame_seed_next;
  logic              take;
  logic [CRC_W-1:0]  seed_cur;

  assign rx.ready = q_ready;
  assign take     = rx.valid && q_ready;
  // seed is latched by the first byte of a frame
  assign seed_cur = frame_open ? frame_seed : crc_seed;

  // decode one stuffed byte
  always_comb begin
    group_left_next   = group_left;
    zero_pending_next = zero_pending;
    frame_open_next   = frame_open;
    frame_seed_next   = frame_seed;
    q_push            = 1'b0;
    q_ent.is_delim    = 1'b0;
    q_ent.data        = rx.rx_byte;
    q_ent.seed        = seed_cur;
    if (take) begin
      if (rx.rx_byte == DELIM_BYTE) begin
        // delimiter ends the frame, a pending zero is dropped
        q_push            = 1'b1;
        q_ent.is_delim    = 1'b1;
        group_left_next   = '0;
        zero_pending_next = 1'b0;
        frame_open_next   = 1'b0;
      end else begin
        frame_open_next = 1'b1;
        frame_seed_next = seed_cur;
        if (group_left == '0) begin
          // code byte: flush the implied zero, open a new group
          q_push            = zero_pending;
          q_ent.data        = DELIM_BYTE;
          group_left_next   = rx.rx_byte - BYTE_W'(1);
          zero_pending_next = (rx.rx_byte != CODE_LONG);
        end else begin
          q_push          = 1'b1;
          group_left_next = group_left - BYTE_W'(1);
        end
      end
    end
  end

  // group state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_left   <= '0;
      zero_pending <= 1'b0;
      frame_open   <= 1'b0;
    end else begin
      group_left   <= group_left_next;
      zero_pending <= zero_pending_next;
      frame_open   <= frame_open_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_seed <= frame_seed_next;
  end

endmodule
`default_nettype wire

// ===== hdl/cdcc_queue.sv =====
// short event queue between front and back
`default_nettype none
`include "cobs_deframer_crc_check_core_assert.svh"
module cdcc_queue
  import cdcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  qent_t     push_ent,
  output logic      push_ready,
  output logic      pop_valid,
  output qent_t     pop_ent,
  input  wire logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign push_ready = (cnt != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_ent    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  `CDCC_ASSERT_IMP(a_q_bound, clk, rst, 1'b1, cnt <= CNT_W'(QUEUE_DEPTH))
  `CDCC_ASSERT_NXT(a_q_grow, clk, rst, do_push && !do_pop, cnt == $past(cnt) + CNT_W'(1))
  `CDCC_ASSERT_NXT(a_q_shrink, clk, rst, do_pop && !do_push, cnt == $past(cnt) - CNT_W'(1))

endmodule
`default_nettype wire

// ===== hdl/cdcc_back.sv =====
// back: holdback, length count, crc and status, result register
`default_nettype none
`include "cobs_deframer_crc_check_core_assert.svh"
module cdcc_back
  import cdcc_pkg::*;
#(
  parameter int MAX_DECODED = MAX_DECODED_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ent_valid,
  input  qent_t                 ent,
  output logic                  ent_ready,
  input  wire logic [LEN_W-1:0] min_frame_bytes,
  cdcc_res_if.source            res
);

  localparam int CNT_W = $clog2(MAX_DECODED + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [1:0] FILL_FULL = 2'd2;

  logic [BYTE_W-1:0] hold0, hold0_next, hold1, hold1_next;
  logic [1:0]        hold_fill, hold_fill_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              ovf, ovf_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic              res_valid;
  res_t              res_q, res_next;
  logic              res_load, step;
  logic [CRC_W-1:0]  crc_cur, trailer;

  assign ent_ready = !res_valid || res.ready;
  assign step      = ent_valid && ent_ready;
  // the frame seed stands in until the first payload byte has left the holdback
  assign crc_cur   = (count > CNT_W'(2)) ? running_crc : ent.seed;
  assign trailer   = {hold1, hold0};

  // one decoded event
  always_comb begin
    hold0_next       = hold0;
    hold1_next       = hold1;
    hold_fill_next   = hold_fill;
    count_next       = count;
    ovf_next         = ovf;
    running_crc_next = running_crc;
    res_load         = 1'b0;
    res_next         = '0;
    if (step) begin
      if (ent.is_delim) begin
        res_load      = 1'b1;
        res_next.kind = KIND_STATUS;
        if (ovf) begin
          res_next.status = ST_LONG;
        end else if ((CMP_W'(count) < CMP_W'(min_frame_bytes)) || (count < CNT_W'(2))) begin
          res_next.status = ST_SHORT;
        end else if (trailer != crc_cur) begin
          res_next.status = ST_CRC_ERR;
        end else begin
          res_next.status = ST_OK;
        end
        res_next.len   = LEN_W'(count);
        res_next.crc   = crc_cur;
        hold_fill_next = '0;
        count_next     = '0;
        ovf_next       = 1'b0;
      end else if (count >= CNT_W'(MAX_DECODED)) begin
        // beyond capacity: byte dropped
        ovf_next = 1'b1;
      end else begin
        count_next = count + CNT_W'(1);
        if (hold_fill == FILL_FULL) begin
          res_load         = 1'b1;
          res_next.kind    = KIND_DATA;
          res_next.data    = hold0;
          running_crc_next = crc_byte(crc_cur, hold0);
          hold0_next       = hold1;
          hold1_next       = ent.data;
        end else if (hold_fill == 2'd0) begin
          hold0_next     = ent.data;
          hold_fill_next = 2'd1;
        end else begin
          hold1_next     = ent.data;
          hold_fill_next = FILL_FULL;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_fill <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      hold_fill <= hold_fill_next;
      count     <= count_next;
      ovf       <= ovf_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // holdback bytes, crc and result payload
  always_ff @(posedge clk) begin
    hold0       <= hold0_next;
    hold1       <= hold1_next;
    running_crc <= running_crc_next;
    if (res_load) begin
      res_q <= res_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.out_kind     = res_q.kind;
  assign res.out_byte     = res_q.data;
  assign res.frame_status = res_q.status;
  assign res.frame_length = res_q.len;
  assign res.computed_crc = res_q.crc;

  `CDCC_ASSERT_IMP(a_ovf_full, clk, rst, ovf, count == CNT_W'(MAX_DECODED))
  `CDCC_ASSERT_IMP(a_fill_track, clk, rst, count < CNT_W'(2), CNT_W'(hold_fill) == count)
  `CDCC_ASSERT_NXT(a_delim_clear, clk, rst, step && ent.is_delim, (count == '0) && !ovf && res_valid)

endmodule
`default_nettype wire

// ===== tb/cobs_deframer_crc_check_core_checker.sv =====
// checker: watches rx, res and apb, predicts the deframer and compares result beats
`timescale 1ns / 100ps
module cobs_deframer_crc_check_core_checker
  import cdcc_pkg::*;
#(
  parameter int MAX_DECODED = MAX_DECODED_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cdcc_rx_if                rx,
  cdcc_res_if               res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                beats_due
);

  // register copies
  logic [CRC_W-1:0] seed_reg;
  logic [LEN_W-1:0] min_len_reg;

  // decoder state
  logic [BYTE_W-1:0] grp_left;
  logic              zero_owed;
  logic [BYTE_W-1:0] held [2];
  int unsigned       held_n;
  logic [CRC_W-1:0]  crc_acc;
  int unsigned       dec_n;
  logic              over;

  // result beats predicted but not yet seen
  res_t frame_beats [$];

  // msb-first crc-16, one byte
  function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      c = {c[CRC_W-2:0], 1'b0} ^ (c[CRC_W-1] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic clear_frame();
    grp_left  = '0;
    zero_owed = 1'b0;
    held[0]   = '0;
    held[1]   = '0;
    held_n    = 0;
    crc_acc   = seed_reg;
    dec_n     = 0;
    over      = 1'b0;
  endtask

  // one decoded byte into the two-byte holdback; the byte pushed out is payload
  task automatic push_decoded(input logic [BYTE_W-1:0] b);
    res_t r;
    if (dec_n >= MAX_DECODED) begin
      over = 1'b1;
      return;
    end
    dec_n++;
    if (held_n >= 2) begin
      crc_acc = crc16_step(crc_acc, held[0]);
      r       = '0;
      r.kind  = KIND_DATA;
      r.data  = held[0];
      frame_beats.push_back(r);
      held[0] = held[1];
      held[1] = b;
    end else begin
      held[held_n] = b;
      held_n++;
    end
  endtask

  // one stuffed byte from the link
  task automatic take_byte(input logic [BYTE_W-1:0] b);
    res_t             r;
    logic [CRC_W-1:0] trailer;
    // nothing of the frame seen yet: crc follows the seed register
    if (grp_left == 0 && !zero_owed && dec_n == 0 && !over) crc_acc = seed_reg;
    if (b == DELIM_BYTE) begin
      trailer = {held[1], held[0]};
      r       = '0;
      r.kind  = KIND_STATUS;
      if (over) r.status = ST_LONG;
      else if (dec_n < min_len_reg || dec_n < 2) r.status = ST_SHORT;
      else if (trailer != crc_acc) r.status = ST_CRC_ERR;
      else r.status = ST_OK;
      r.len = LEN_W'(dec_n);
      r.crc = crc_acc;
      frame_beats.push_back(r);
      clear_frame();
    end else if (grp_left == 0) begin
      // code byte: the zero owed by the previous group goes out first
      if (zero_owed) push_decoded(8'h00);
      grp_left  = b - 8'd1;
      zero_owed = (b != CODE_LONG);
    end else begin
      grp_left = grp_left - 8'd1;
      push_decoded(b);
    end
  endtask

  task automatic check_field(input string what, input logic [CRC_W-1:0] want,
                             input logic [CRC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin : watch_beats
    res_t want;
    res_t got;
    if (rst) begin
      seed_reg    = CRC_SEED_RST;
      min_len_reg = MIN_LEN_RST;
      clear_frame();
      frame_beats.delete();
      mismatches  = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_CRC_SEED: seed_reg    = pwdata[CRC_W-1:0];
          REG_MIN_LEN:  min_len_reg = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) take_byte(rx.rx_byte);
      // result beat against the oldest prediction
      if (res.valid && res.ready) begin
        got.kind   = kind_t'(res.out_kind);
        got.data   = res.out_byte;
        got.status = status_t'(res.frame_status);
        got.len    = res.frame_length;
        got.crc    = res.computed_crc;
        if (frame_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got kind %0d byte %0h",
                   $time, got.kind, got.data);
          mismatches++;
        end else begin
          want = frame_beats.pop_front();
          check_field("out_kind", want.kind, got.kind);
          check_field("out_byte", want.data, got.data);
          check_field("frame_status", want.status, got.status);
          check_field("frame_length", want.len, got.len);
          check_field("computed_crc", want.crc, got.crc);
        end
      end
    end
    beats_due = frame_beats.size();
  end

endmodule

// ===== tb/cobs_deframer_crc_check_core_tb.sv =====
// testbench top: clock, reset, frame stimulus, register writes and verdict
`timescale 1ns / 100ps
module cobs_deframer_crc_check_core_tb;
  import cdcc_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                beats_due;

  cdcc_rx_if  rx_ch ();
  cdcc_res_if res_ch ();

  cobs_deframer_crc_check_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cobs_deframer_crc_check_core_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  // stimulus state
  logic [CRC_W-1:0]  seed_now;
  logic [BYTE_W-1:0] payload_q [$];
  int unsigned       bytes_sent;
  bit                src_calm;
  bit                sink_calm;
  int unsigned       hold_left;
  int unsigned       stall_pick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("cobs_deframer_crc_check_core_tb: done, errors");
    $finish;
  end

  // result side: random stall after each beat, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      sink_calm    <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
      if (res_ch.valid && res_ch.ready) begin
        stall_pick = sink_calm ? 0 : $urandom_range(0, 16);
        hold_left    <= stall_pick;
        res_ch.ready <= (stall_pick == 0);
      end else if (!res_ch.ready) begin
        if (hold_left <= 1) begin
          res_ch.ready <= 1'b1;
          hold_left    <= 0;
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    end
  end

  // reference crc for building trailers
  function automatic logic [CRC_W-1:0] crc_over(input logic [CRC_W-1:0] init,
                                                input logic [BYTE_W-1:0] data [$]);
    logic [CRC_W-1:0] c;
    c = init;
    foreach (data[i]) begin
      c ^= {data[i], 8'h00};
      repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // one rx beat; valid stays high when the next beat follows at once
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = src_calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // stop sending, let every predicted beat drain, then give the pipe time to settle
  task automatic drain_and_pause();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CRC_SEED) seed_now = value[CRC_W-1:0];
  endtask

  task automatic fill_payload(input int unsigned n, input int unsigned zero_pct);
    payload_q.delete();
    repeat (n) begin
      payload_q.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00
                                                            : 8'($urandom_range(1, 255)));
    end
  endtask

  // payload plus trailer (low byte first), cobs stuffed, optionally cut short, then delimiter
  task automatic send_frame(input bit crc_good, input int unsigned chop);
    logic [CRC_W-1:0]  sum;
    logic [BYTE_W-1:0] blk [$];
    logic [BYTE_W-1:0] line [$];
    sum = crc_over(seed_now, payload_q);
    if (!crc_good) sum ^= 16'($urandom_range(1, 65535));
    payload_q.push_back(sum[7:0]);
    payload_q.push_back(sum[15:8]);
    foreach (payload_q[i]) begin
      if (payload_q[i] == 8'h00) begin
        line.push_back(8'(blk.size() + 1));
        line = {line, blk};
        blk.delete();
      end else begin
        blk.push_back(payload_q[i]);
        // full group of 254 carries no implied zero
        if (blk.size() == 254) begin
          line.push_back(CODE_LONG);
          line = {line, blk};
          blk.delete();
        end
      end
    end
    line.push_back(8'(blk.size() + 1));
    line = {line, blk};
    repeat (chop) if (line.size() > 0) void'(line.pop_back());
    foreach (line[i]) push_byte(line[i]);
    push_byte(DELIM_BYTE);
  endtask

  // mostly well-formed frames, some bad crc, cut groups, raw noise and empty frames
  task automatic random_frame();
    int unsigned pick;
    int unsigned n;
    pick     = $urandom_range(0, 99);
    n        = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 80) : $urandom_range(0, 20);
    src_calm = ($urandom_range(0, 3) == 0);
    fill_payload(n, $urandom_range(0, 40));
    if (pick < 70) begin
      send_frame(1'b1, 0);
    end else if (pick < 80) begin
      send_frame(1'b0, 0);
    end else if (pick < 88) begin
      send_frame(1'b1, $urandom_range(1, 3));
    end else if (pick < 95) begin
      repeat (n) push_byte(8'($urandom_range(0, 255)));
      push_byte(DELIM_BYTE);
    end else begin
      push_byte(DELIM_BYTE);
    end
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned guard;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    seed_now   = CRC_SEED_RST;
    bytes_sent = 0;
    src_calm   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frame, then a long code cut off after two data bytes (too short)
    push_byte(DELIM_BYTE);
    push_byte(CODE_LONG);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(DELIM_BYTE);

    // no length floor: one decoded byte is still short of a trailer
    drain_and_pause();
    write_reg(REG_MIN_LEN, 32'd0);
    push_byte(8'h02);
    push_byte(8'hAA);
    push_byte(DELIM_BYTE);

    // zero payload byte with good trailer, then a bad trailer
    payload_q = {8'h00};
    send_frame(1'b1, 0);
    payload_q = {8'h55};
    send_frame(1'b0, 0);

    // seed written mid-frame only counts from the next frame; frame ends inside a group
    push_byte(8'h04);
    push_byte(8'h12);
    drain_and_pause();
    write_reg(REG_CRC_SEED, 32'h0000);
    push_byte(8'h34);
    push_byte(DELIM_BYTE);

    // trailer only, under the new seed
    payload_q.delete();
    send_frame(1'b1, 0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_pause();
      case (ph)
        0: begin
          write_reg(REG_CRC_SEED, 32'h0000);
          write_reg(REG_MIN_LEN, 32'd0);
        end
        1: begin
          write_reg(REG_CRC_SEED, 32'($urandom_range(0, 65535)));
          write_reg(REG_MIN_LEN, 32'($urandom_range(2, 12)));
        end
        2: begin
          // largest floor: exactly full capacity passes, ten bytes beyond it overflows
          write_reg(REG_CRC_SEED, 32'h0000FFFF);
          write_reg(REG_MIN_LEN, 32'd512);
          fill_payload(MAX_DECODED_DEF - 2, 0);
          send_frame(1'b1, 0);
          fill_payload(MAX_DECODED_DEF + 8, 2);
          send_frame(1'b1, 0);
        end
        3: begin
          write_reg(REG_CRC_SEED, 32'($urandom_range(0, 65535)));
          write_reg(REG_MIN_LEN, 32'd1);
        end
        default: begin
          write_reg(REG_CRC_SEED, 32'h0000FFFF);
          write_reg(REG_MIN_LEN, 32'd10);
        end
      endcase
      phase_end = bytes_sent + 12;
      while (bytes_sent < phase_end) random_frame();
    end

    // wait for the last beats, bounded
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (beats_due != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && beats_due == 0) begin
      $display("cobs_deframer_crc_check_core_tb: done, clean");
    end else begin
      $display("cobs_deframer_crc_check_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cdcc_pkg.sv
hdl/cdcc_rx_if.sv
hdl/cdcc_res_if.sv
hdl/cdcc_front.sv
hdl/cdcc_queue.sv
hdl/cdcc_back.sv
hdl/cobs_deframer_crc_check_core.sv
tb/cobs_deframer_crc_check_core_checker.sv
tb/cobs_deframer_crc_check_core_tb.sv
